@@ rtl/sliding_window_maximum_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Sliding window maximum: assertion macros
// Shared macros for the concurrent checks on the unit's ports.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAXIMUM_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_UNIT_ASSERT_SVH

// same-cycle implication, muted during reset
`define SWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("swm assertion failed");

// next-cycle implication, muted during reset
`define SWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("swm assertion failed");

`endif

@@ rtl/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// Sliding window maximum: package
// Shared constants and the cell control bundle.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int MAX_WINDOW_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int CFG_W           = 7;

	localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(3);

	// broadcast to every cell
	typedef struct packed {
		logic take;   // transaction accepted this cycle
		logic shift;  // move contents one cell toward the front
		logic start;  // discard all candidates
	} swm_ctl_t;

endpackage

@@ rtl/swm_if.sv @@
// ----------------------------------------------------------------------------
// Sliding window maximum: stream interfaces
// Valid/ready channels for samples and window maxima.
// ----------------------------------------------------------------------------
interface swm_in_if #(
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          start_of_sequence;

	modport source (output valid, output sample, output start_of_sequence, input ready);
	modport sink   (input valid, input sample, input start_of_sequence, output ready);
endinterface

interface swm_out_if #(
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] window_max;

	modport source (output valid, output window_max, input ready);
	modport sink   (input valid, input window_max, output ready);
endinterface

@@ rtl/sliding_window_maximum_unit.sv @@
// ----------------------------------------------------------------------------
// Sliding window maximum unit
// Monotonic run of candidate maxima kept in a row of cells; cell 0 is the
// front and holds the maximum of the current window.
//
//  channel  dir  handshake       payload
//  stream   in   valid/ready     sample, start_of_sequence
//  peak     out  valid/ready     window_max
//  cfg      in   cfg_we          cfg_wdata (window_size)
//
// One transaction per cycle while stream.ready is high; the result is registered and shown in the cycle after accept.
// No result until window_size samples have arrived since the sequence start.
// After a write that shrinks the window, expired front candidates are shifted
// out one per cycle with stream.ready low.
// Reset empties all cells and sets window_size to 3.
// stream.ready is low while a result waits and peak.ready is low.
// ----------------------------------------------------------------------------
module sliding_window_maximum_unit #(
	parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	swm_in_if.sink                     stream,
	swm_out_if.source                  peak,
	input  logic                       cfg_we,
	input  logic [swm_pkg::CFG_W-1:0]  cfg_wdata
);
	import swm_pkg::*;

	localparam int AGE_W = $clog2(MAX_WINDOW + 1);

	logic [CFG_W-1:0]              win_q;
	logic [AGE_W-1:0]              w_eff;
	logic [AGE_W-1:0]              seen_q;
	logic [AGE_W-1:0]              seen_a;
	logic [AGE_W-1:0]              seen_b;
	logic [AGE_W-1:0]              seen_d;
	logic                          emit;
	logic                          trimming;
	logic                          drop;
	logic                          take;
	swm_ctl_t                      ctl;
	logic signed [SAMPLE_BITS-1:0] front_d;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;

	logic                          c_valid [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] c_value [MAX_WINDOW];
	logic [AGE_W-1:0]              c_age   [MAX_WINDOW];
	logic                          c_keep  [MAX_WINDOW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			win_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (win_q == '0) begin
			w_eff = AGE_W'(1);
		end else if (32'(win_q) > 32'(MAX_WINDOW)) begin
			w_eff = AGE_W'(MAX_WINDOW);
		end else begin
			w_eff = AGE_W'(win_q);
		end
	end

	assign trimming = c_valid[0] && (c_age[0] >= w_eff);
	assign drop     = c_valid[0] && (c_age[0] >= (w_eff - AGE_W'(1)));

	assign stream.ready = !trimming && (!out_valid_q || peak.ready);
	assign take         = stream.valid && stream.ready;

	always_comb begin
		ctl.take  = take;
		ctl.start = stream.start_of_sequence;
		ctl.shift = take ? (drop && !stream.start_of_sequence) : trimming;
	end

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic                          n_valid;
		logic signed [SAMPLE_BITS-1:0] n_value;
		logic [AGE_W-1:0]              n_age;
		logic                          p_keep;

		if (i == MAX_WINDOW - 1) begin : g_last
			assign n_valid = 1'b0;
			assign n_value = '0;
			assign n_age   = '0;
		end else begin : g_mid
			assign n_valid = c_valid[i+1];
			assign n_value = c_value[i+1];
			assign n_age   = c_age[i+1];
		end

		if (i == 0) begin : g_head
			assign p_keep = 1'b1;
		end else begin : g_tail
			assign p_keep = c_keep[i-1];
		end

		swm_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.AGE_W       (AGE_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.sample    (stream.sample),
			.win       (w_eff),
			.nxt_valid (n_valid),
			.nxt_value (n_value),
			.nxt_age   (n_age),
			.prev_keep (p_keep),
			.keep      (c_keep[i]),
			.valid     (c_valid[i]),
			.value     (c_value[i]),
			.age       (c_age[i])
		);
	end

	always_comb begin
		if (!c_keep[0]) begin
			front_d = stream.sample;
		end else if (ctl.shift) begin
			front_d = c_value[1];
		end else begin
			front_d = c_value[0];
		end
	end

	always_comb begin
		seen_a = stream.start_of_sequence ? '0 : seen_q;
		seen_b = (seen_a > w_eff) ? w_eff : seen_a;
		seen_d = (seen_b < w_eff) ? seen_b + AGE_W'(1) : seen_b;
		emit   = (seen_d >= w_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (take) begin
			seen_q      <= seen_d;
			out_valid_q <= emit;
		end else if (peak.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= front_d;
		end
	end

	assign peak.valid      = out_valid_q;
	assign peak.window_max = out_data_q;

endmodule

@@ rtl/swm_cell.sv @@
// ----------------------------------------------------------------------------
// Sliding window maximum: candidate cell
// Holds one candidate (value, age); keeps it, takes the new sample or
// empties, and shifts toward the front when the front candidate expires.
// ----------------------------------------------------------------------------
module swm_cell #(
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
	parameter int AGE_W       = $clog2(swm_pkg::MAX_WINDOW_DEF + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swm_pkg::swm_ctl_t             ctl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [AGE_W-1:0]              win,
	input  logic                          nxt_valid,
	input  logic signed [SAMPLE_BITS-1:0] nxt_value,
	input  logic [AGE_W-1:0]              nxt_age,
	input  logic                          prev_keep,
	output logic                          keep,
	output logic                          valid,
	output logic signed [SAMPLE_BITS-1:0] value,
	output logic [AGE_W-1:0]              age
);
	import swm_pkg::*;

	logic                          valid_q;
	logic signed [SAMPLE_BITS-1:0] value_q;
	logic [AGE_W-1:0]              age_q;

	logic                          sel_valid;
	logic signed [SAMPLE_BITS-1:0] sel_value;
	logic [AGE_W-1:0]              sel_age;
	logic [AGE_W-1:0]              age_inc;
	logic                          ins;

	always_comb begin
		sel_valid = ctl.shift ? nxt_valid : valid_q;
		sel_value = ctl.shift ? nxt_value : value_q;
		sel_age   = ctl.shift ? nxt_age   : age_q;
		age_inc   = sel_age + AGE_W'(1);
		keep      = !ctl.start && sel_valid && (sel_value >= sample) && (age_inc < win);
		ins       = !keep && prev_keep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.take) begin
			valid_q <= keep || ins;
		end else if (ctl.shift) begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			if (keep) begin
				value_q <= sel_value;
				age_q   <= age_inc;
			end else begin
				value_q <= sample;
				age_q   <= '0;
			end
		end else if (ctl.shift) begin
			value_q <= nxt_value;
			age_q   <= nxt_age;
		end
	end

	assign valid = valid_q;
	assign value = value_q;
	assign age   = age_q;

endmodule

@@ rtl/swm_checker.sv @@
// ----------------------------------------------------------------------------
// Sliding window maximum: port checker
// Checks the unit's ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "sliding_window_maximum_unit_assert.svh"

module swm_checker #(
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic signed [SAMPLE_BITS-1:0] in_sample,
	input logic                          in_start,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] out_max,
	input logic                          cfg_we,
	input logic [swm_pkg::CFG_W-1:0]     cfg_wdata
);
	import swm_pkg::*;

	logic unit_win_q;
	logic in_acc;

	assign in_acc = in_valid && in_ready;

	// window of one (or zero, which acts as one)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_win_q <= 1'b0;
		end else if (cfg_we) begin
			unit_win_q <= (cfg_wdata == CFG_W'(0)) || (cfg_wdata == CFG_W'(1));
		end
	end

	`SWM_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`SWM_ASSERT_IMP(a_no_spurious, clk, arst_n, $rose(out_valid), $past(in_acc))
	`SWM_ASSERT_NXT(a_unit_window, clk, arst_n, in_acc && unit_win_q, out_valid && (out_max == $past(in_sample)))
	`SWM_ASSERT_NXT(a_start_quiet, clk, arst_n, in_acc && in_start && !unit_win_q, !out_valid)

endmodule

bind sliding_window_maximum_unit swm_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_swm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (stream.valid),
	.in_ready  (stream.ready),
	.in_sample (stream.sample),
	.in_start  (stream.start_of_sequence),
	.out_valid (peak.valid),
	.out_ready (peak.ready),
	.out_max   (peak.window_max),
	.cfg_we    (cfg_we),
	.cfg_wdata (cfg_wdata)
);
